>>> hw/rtl/sbr_pkg.sv
package sbr_pkg;

    localparam int POS_W        = 64;
    localparam int BYTE_W       = 8;
    localparam int ROOM_W       = 7;
    localparam int CAPACITY_DEF = 64;

    // s_tdata layout, lowest bit up: position, byte_value, room
    localparam int S_DATA_W = ((POS_W + BYTE_W + ROOM_W + 7) / 8) * 8;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

>>> hw/rtl/sbr_alu.sv
module sbr_alu
    import sbr_pkg::*;
(
    input  alu_op_t            op,
    input  logic [POS_W-1:0]   a,
    input  logic [POS_W-1:0]   b,
    output logic [POS_W-1:0]   sum,
    output logic               carry
);

    logic [POS_W-1:0] b_eff;
    logic [POS_W:0]   full;

    // subtract as a + ~b + 1; carry set means no borrow
    assign b_eff = (op == ALU_SUB) ? ~b : b;
    assign full  = {1'b0, a} + {1'b0, b_eff} + {{POS_W{1'b0}}, (op == ALU_SUB)};
    assign sum   = full[POS_W-1:0];
    assign carry = full[POS_W];

endmodule

>>> hw/rtl/sbr_store.sv
module sbr_store
    import sbr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [$clog2(CAPACITY)-1:0]     wr_slot,
    input  logic [BYTE_W-1:0]               wr_byte,
    input  logic                            rd_en,
    input  logic [$clog2(CAPACITY)-1:0]     rd_slot,
    output logic [BYTE_W-1:0]               rd_byte,
    output logic [CAPACITY-1:0]             present
);

    logic [BYTE_W-1:0]   mem [CAPACITY];
    logic [CAPACITY-1:0] present_reg;
    logic [BYTE_W-1:0]   rd_byte_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_slot] <= wr_byte;
        end
        if (rd_en) begin
            rd_byte_reg <= mem[rd_slot];
        end
    end

    // reading an entry releases it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
        end else begin
            if (wr_en) begin
                present_reg[wr_slot] <= 1'b1;
            end
            if (rd_en) begin
                present_reg[rd_slot] <= 1'b0;
            end
        end
    end

    assign rd_byte = rd_byte_reg;
    assign present = present_reg;

endmodule

>>> hw/rtl/stream_byte_reassembler.sv
// Channel | Dir | Group                     | Contents
// s_      | in  | tvalid tready tdata tuser  | one byte or empty marker, room; tlast ends stream
// m_      | out | tvalid tready tdata tuser  | released byte, flags; tlast ends the item's run
//
// An item that releases nothing goes through acceptance, five passes through one shared
// 64-bit adder (limit, limit compare, end mark, two window bounds), a head check and a
// close check. Each released byte adds a drain step (the adder steps the position) and a
// fetch step (the store read is registered); a release at the top position skips the
// last head check. After the stream closes an item is taken and dropped.
// Reset clears next position, limit, end mark and ring store valid bits; no clearing pass.
// A stalled m_ side holds the sequencer once one released byte is waiting.
module stream_byte_reassembler
    import sbr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // position[63:0], byte_value[71:64], room[78:72]
    input  logic                  s_tuser,   // carries_byte
    input  logic                  s_tlast,   // last_of_stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,   // out_byte[7:0]
    output logic [1:0]            m_tuser,   // out_valid[0], stream_done[1]
    output logic                  m_tlast    // last_of_run
);

    localparam int SLOT_W = $clog2(CAPACITY);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIM,
        ST_LCMP,
        ST_END,
        ST_LO,
        ST_HI,
        ST_DRAIN,
        ST_FETCH,
        ST_CLOSE
    } state_t;

    state_t              state_reg, state_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                has_reg, has_next;
    logic                last_reg, last_next;
    logic [ROOM_W-1:0]   room_reg, room_next;
    logic [POS_W-1:0]    next_pos_reg, next_pos_next;
    logic [POS_W-1:0]    limit_reg, limit_next;
    logic [POS_W-1:0]    end_reg, end_next;
    logic                end_known_reg, end_known_next;
    logic                closed_reg, closed_next;
    logic [POS_W-1:0]    lim_reg, lim_next;
    logic                ge_reg, ge_next;
    logic [SLOT_W-1:0]   off_reg, off_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic                sat_reg, sat_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [BYTE_W-1:0]   pend_byte_reg, pend_byte_next;
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_byte_reg, m_byte_next;
    logic                m_ok_reg, m_ok_next;
    logic                m_done_reg, m_done_next;
    logic                m_last_reg, m_last_next;

    alu_op_t             alu_op;
    logic [POS_W-1:0]    alu_a, alu_b, alu_sum, alu_sat;
    logic                alu_carry;

    logic                wr_en, rd_en;
    logic [BYTE_W-1:0]   rd_byte;
    logic [CAPACITY-1:0] present;
    logic [SLOT_W:0]     slot_sum;
    logic [SLOT_W-1:0]   wr_slot;
    logic [ROOM_W-1:0]   room_in;
    logic                out_free;
    logic                done;

    sbr_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    sbr_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_slot (wr_slot),
        .wr_byte (byte_reg),
        .rd_en   (rd_en),
        .rd_slot (head_reg),
        .rd_byte (rd_byte),
        .present (present)
    );

    assign alu_sat  = alu_carry ? {POS_W{1'b1}} : alu_sum;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // room clipped to the ring size
    assign room_in = (s_tdata[POS_W+BYTE_W +: ROOM_W] > ROOM_W'(CAPACITY))
                   ? ROOM_W'(CAPACITY) : s_tdata[POS_W+BYTE_W +: ROOM_W];

    // offset below CAPACITY, so one wrap at most
    assign slot_sum = {1'b0, head_reg} + {1'b0, off_reg};
    assign wr_slot  = (slot_sum >= (SLOT_W+1)'(CAPACITY))
                    ? SLOT_W'(slot_sum - (SLOT_W+1)'(CAPACITY)) : slot_sum[SLOT_W-1:0];

    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = next_pos_reg;
        alu_b  = '0;
        case (state_reg)
            ST_LIM: begin
                alu_b = {{(POS_W-ROOM_W){1'b0}}, room_reg};
            end
            ST_LCMP: begin
                alu_op = ALU_SUB;
                alu_a  = limit_reg;
                alu_b  = lim_reg;
            end
            ST_END: begin
                alu_a = pos_reg;
                alu_b = {{(POS_W-1){1'b0}}, has_reg};
            end
            ST_LO: begin
                alu_op = ALU_SUB;
                alu_a  = pos_reg;
                alu_b  = next_pos_reg;
            end
            ST_HI: begin
                alu_op = ALU_SUB;
                alu_a  = pos_reg;
                alu_b  = limit_reg;
            end
            ST_DRAIN: begin
                alu_b = {{(POS_W-1){1'b0}}, 1'b1};
            end
            ST_CLOSE: begin
                alu_op = ALU_SUB;
                alu_b  = end_reg;
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        byte_next       = byte_reg;
        has_next        = has_reg;
        last_next       = last_reg;
        room_next       = room_reg;
        next_pos_next   = next_pos_reg;
        limit_next      = limit_reg;
        end_next        = end_reg;
        end_known_next  = end_known_reg;
        closed_next     = closed_reg;
        lim_next        = lim_reg;
        ge_next         = ge_reg;
        off_next        = off_reg;
        head_next       = head_reg;
        sat_next        = sat_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_byte_next     = m_byte_reg;
        m_ok_next       = m_ok_reg;
        m_done_next     = m_done_reg;
        m_last_next     = m_last_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        done            = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pos_next  = s_tdata[POS_W-1:0];
                    byte_next = s_tdata[POS_W +: BYTE_W];
                    room_next = room_in;
                    has_next  = s_tuser;
                    last_next = s_tlast;
                    // drop everything once closed
                    if (!closed_reg) begin
                        state_next = ST_LIM;
                    end
                end
            end
            ST_LIM: begin
                lim_next   = alu_sat;
                state_next = ST_LCMP;
            end
            ST_LCMP: begin
                // borrow: limit below the new candidate
                if (!alu_carry) begin
                    limit_next = lim_reg;
                end
                state_next = ST_END;
            end
            ST_END: begin
                if (last_reg) begin
                    end_next       = alu_sat;
                    end_known_next = 1'b1;
                end
                state_next = ST_LO;
            end
            ST_LO: begin
                ge_next    = alu_carry;
                off_next   = alu_sum[SLOT_W-1:0];
                state_next = ST_HI;
            end
            ST_HI: begin
                // keep the first copy of a duplicate
                if (has_reg && ge_reg && !alu_carry && !present[wr_slot]) begin
                    wr_en = 1'b1;
                end
                state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (present[head_reg]) begin
                    rd_en    = 1'b1;
                    sat_next = alu_carry;
                    // hold position at the top of the range
                    if (!alu_carry) begin
                        next_pos_next = alu_sum;
                        head_next     = (head_reg == SLOT_W'(CAPACITY - 1))
                                      ? '0 : head_reg + SLOT_W'(1);
                    end
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_CLOSE;
                end
            end
            ST_FETCH: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_byte_next  = pend_byte_reg;
                        m_ok_next    = 1'b1;
                        m_done_next  = 1'b0;
                        m_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_byte_next  = rd_byte;
                    state_next      = sat_reg ? ST_CLOSE : ST_DRAIN;
                end
            end
            ST_CLOSE: begin
                done = end_known_reg && (alu_sum == '0);
                if (!pend_valid_reg && !done) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_byte_next     = pend_valid_reg ? pend_byte_reg : '0;
                    m_ok_next       = pend_valid_reg;
                    m_done_next     = done;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    closed_next     = done;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            next_pos_reg   <= '0;
            limit_reg      <= '0;
            end_reg        <= '0;
            end_known_reg  <= 1'b0;
            closed_reg     <= 1'b0;
            head_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            next_pos_reg   <= next_pos_next;
            limit_reg      <= limit_next;
            end_reg        <= end_next;
            end_known_reg  <= end_known_next;
            closed_reg     <= closed_next;
            head_reg       <= head_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pos_reg       <= pos_next;
        byte_reg      <= byte_next;
        has_reg       <= has_next;
        last_reg      <= last_next;
        room_reg      <= room_next;
        lim_reg       <= lim_next;
        ge_reg        <= ge_next;
        off_reg       <= off_next;
        sat_reg       <= sat_next;
        pend_byte_reg <= pend_byte_next;
        m_byte_reg    <= m_byte_next;
        m_ok_reg      <= m_ok_next;
        m_done_reg    <= m_done_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = {m_done_reg, m_ok_reg};
    assign m_tlast  = m_last_reg;

endmodule
